// File: rtl/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: lead rule and status codes, byte masks,
// and the decode state and result types. No dependencies.
package utf8d_pkg;

  typedef enum logic [1:0] {
    RULE_STRICT = 2'd0,
    RULE_RANGE  = 2'd1,
    RULE_MASK   = 2'd2
  } lead_rule_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  localparam int unsigned CP_WIDTH    = 21;
  localparam int unsigned LEN_WIDTH   = 3;
  localparam int unsigned CHARS_WIDTH = 32;

  localparam logic [7:0] MASK_LEN2 = 8'h1F;
  localparam logic [7:0] MASK_LEN3 = 8'h0F;
  localparam logic [7:0] MASK_LEN4 = 8'h07;

  // Decoding state carried from byte to byte.
  typedef struct packed {
    logic [1:0]           bytes_left;
    logic [LEN_WIDTH-1:0] cur_length;
    logic [CP_WIDTH-1:0]  accumulator;
  } dec_state_t;

  // What one byte causes, before the counter is applied.
  typedef struct packed {
    logic                 emit;
    logic                 count_inc;
    logic                 done;
    logic [CP_WIDTH-1:0]  code_point;
    logic [LEN_WIDTH-1:0] seq_length;
    status_t              status;
  } step_res_t;

  // One result item as presented on the output.
  typedef struct packed {
    logic [CP_WIDTH-1:0]    code_point;
    logic [LEN_WIDTH-1:0]   seq_length;
    status_t                status;
    logic [CHARS_WIDTH-1:0] char_count;
    logic                   text_done;
  } result_t;

endpackage

// File: rtl/utf8d_step.sv
// One-byte UTF-8 decode step: lead byte classification and payload shift-in.
// Pure combinational; depends on utf8d_pkg.
module utf8d_step import utf8d_pkg::*; (
  input  logic       [7:0] data_byte,
  input  logic             end_of_text,
  input  lead_rule_t       lead_rule,
  input  dec_state_t       state_cur,
  output dec_state_t       state_nxt,
  output step_res_t        res
);

  logic [LEN_WIDTH-1:0] lead_len;
  logic [CP_WIDTH-1:0]  acc_shift;
  logic [1:0]           left_dec;

  // Sequence length of a lead byte; zero marks an invalid lead.
  always_comb begin
    lead_len = '0;
    if (data_byte <= 8'h7F) begin
      lead_len = 3'd1;
    end else begin
      case (lead_rule)
        RULE_RANGE: begin
          if (data_byte inside {[8'hC0:8'hDF]}) lead_len = 3'd2;
          else if (data_byte inside {[8'hE0:8'hEF]}) lead_len = 3'd3;
          else if (data_byte inside {[8'hF0:8'hFF]}) lead_len = 3'd4;
        end
        RULE_MASK: begin
          if (data_byte inside {[8'hC0:8'hDF]}) lead_len = 3'd2;
          else if (data_byte inside {[8'hE0:8'hEF]}) lead_len = 3'd3;
          else if (data_byte inside {[8'hF0:8'hF7]}) lead_len = 3'd4;
        end
        default: begin
          if (data_byte inside {[8'hC2:8'hDF]}) lead_len = 3'd2;
          else if (data_byte inside {[8'hE0:8'hEF]}) lead_len = 3'd3;
          else if (data_byte inside {[8'hF0:8'hF4]}) lead_len = 3'd4;
        end
      endcase
    end
  end

  assign acc_shift = {state_cur.accumulator[CP_WIDTH-7:0], data_byte[5:0]};
  assign left_dec  = state_cur.bytes_left - 2'd1;

  always_comb begin
    state_nxt      = state_cur;
    res.emit       = 1'b0;
    res.count_inc  = 1'b0;
    res.done       = end_of_text;
    res.code_point = '0;
    res.seq_length = '0;
    res.status     = ST_OK;
    if (state_cur.bytes_left == 2'd0) begin
      case (lead_len)
        3'd0: begin
          res.emit   = 1'b1;
          res.status = ST_BAD_LEAD;
        end
        3'd1: begin
          res.emit       = 1'b1;
          res.count_inc  = 1'b1;
          res.code_point = CP_WIDTH'(data_byte);
          res.seq_length = 3'd1;
        end
        default: begin
          case (lead_len)
            3'd2:    state_nxt.accumulator = CP_WIDTH'(data_byte & MASK_LEN2);
            3'd3:    state_nxt.accumulator = CP_WIDTH'(data_byte & MASK_LEN3);
            default: state_nxt.accumulator = CP_WIDTH'(data_byte & MASK_LEN4);
          endcase
          state_nxt.cur_length = lead_len;
          state_nxt.bytes_left = 2'(lead_len - 3'd1);
          if (end_of_text) begin
            res.emit   = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end
      endcase
    end else if (left_dec == 2'd0) begin
      // Last continuation byte: the character is complete.
      res.emit       = 1'b1;
      res.count_inc  = 1'b1;
      res.code_point = acc_shift;
      res.seq_length = state_cur.cur_length;
      state_nxt      = '0;
    end else begin
      state_nxt.accumulator = acc_shift;
      state_nxt.bytes_left  = left_dec;
      if (end_of_text) begin
        res.emit   = 1'b1;
        res.status = ST_TRUNCATED;
      end
    end
  end

endmodule

// File: rtl/utf8_stream_decoder_counter.sv
// Top level of the UTF-8 stream decoder with character counter.
// Depends on utf8d_pkg and utf8d_step.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid / in_stall  in_data_byte[7:0], in_end_of_text
//   out_      result     out_valid/out_stall  out_code_point[20:0], out_seq_length[2:0],
//                                             out_status[1:0], out_char_count[31:0],
//                                             out_text_done
//   cfg_      write      cfg_valid/cfg_ready  cfg_lead_rule[1:0]
//
// One request is taken per clock while in_stall is low. The decode and the
// counter update run in the accept cycle; the result is registered for out_.
// A two-entry output buffer (result register plus skid) holds results while
// out_stall is high; in_stall rises only when the skid entry is occupied.
// Reset (rst_n low at a clock edge) clears the decoding state, the counter,
// the lead rule (strict) and both buffer entries. No clearing pass is needed.
module utf8_stream_decoder_counter import utf8d_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_text,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CP_WIDTH-1:0]    out_code_point,
  output logic [LEN_WIDTH-1:0]   out_seq_length,
  output logic [1:0]             out_status,
  output logic [CHARS_WIDTH-1:0] out_char_count,
  output logic                   out_text_done,
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_lead_rule
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  lead_rule_t             lead_rule_r;
  dec_state_t             state_r, state_nxt, step_state;
  step_res_t              step_res;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_upd;
  result_t                res_new;
  result_t                out_r, out_nxt, skid_r, skid_nxt;
  logic                   out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                   in_acc, out_take, load;

  // Configuration register; the port never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_rule_r <= RULE_STRICT;
    end else if (cfg_valid && cfg_ready) begin
      lead_rule_r <= lead_rule_t'(cfg_lead_rule);
    end
  end

  // Decode the accepted byte against the current state.
  utf8d_step u_step (
    .data_byte   (in_data_byte),
    .end_of_text (in_end_of_text),
    .lead_rule   (lead_rule_r),
    .state_cur   (state_r),
    .state_nxt   (step_state),
    .res         (step_res)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign load     = in_acc && step_res.emit;

  // Advance the counter, saturating at all ones.
  assign count_upd = (step_res.count_inc && (count_r != COUNT_MAX)) ? count_r + 1'b1
                                                                    : count_r;

  // End of text drops all decoding state and the count after the result.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    if (in_acc) begin
      if (step_res.done) begin
        state_nxt = '0;
        count_nxt = '0;
      end else begin
        state_nxt = step_state;
        count_nxt = count_upd;
      end
    end
  end

  // The result carries the low bits of the counter.
  always_comb begin
    res_new.code_point = step_res.code_point;
    res_new.seq_length = step_res.seq_length;
    res_new.status     = step_res.status;
    res_new.char_count = CHARS_WIDTH'(count_upd);
    res_new.text_done  = step_res.done;
  end

  // Output buffer: the skid entry drains into the result register first.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res_new;
        out_valid_nxt = load;
      end
    end else if (load) begin
      skid_nxt       = res_new;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_seq_length = out_r.seq_length;
  assign out_status     = out_r.status;
  assign out_char_count = out_r.char_count;
  assign out_text_done  = out_r.text_done;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while result register empty");

  // An end-of-text request leaves the decoder and counter cleared.
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_text) |=> (state_r == '0 && count_r == '0))
    else $error("state not cleared after end of text");

  // Error results carry no code point and no length.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |->
      (out_r.code_point == '0 && out_r.seq_length == '0))
    else $error("error result with nonzero payload");

  // A good result always has a length of one to four bytes.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OK) |->
      (out_r.seq_length != '0 && out_r.seq_length <= 3'd4))
    else $error("ok result with bad length");
`endif

endmodule
